// ===== rtl/sfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter package
// Shared widths, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 17;
  localparam int FETCH_W     = 18;
  localparam int COORD_W     = 16;
  localparam int SCALE_W     = 4;
  localparam int DEST_W      = 10;
  localparam int BASE_W      = 16;
  localparam int STRIDE_W    = 11;
  localparam int FSIZE_W     = 7;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ALPHA_SHIFT = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X,
    CFG_DEST_Y,
    CFG_SRC_BASE,
    CFG_SHEET_WIDTH,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_SCALE,
    CFG_MIRROR
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_BASE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic base;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ===== rtl/sfb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter channels
// Valid/ready channels for source pixels and framebuffer results.
// ----------------------------------------------------------------------------
interface sfb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink (input valid, input pixel_color, output ready);
endinterface

interface sfb_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [16:0] pixel_address;
  logic [31:0] write_color;
  logic        last;
  logic [17:0] fetch_address;
  logic        frame_done;

  modport source (output valid, output write_enable, output pixel_address,
                  output write_color, output last, output fetch_address,
                  output frame_done, input ready);
  modport sink (input valid, input write_enable, input pixel_address,
                input write_color, input last, input fetch_address,
                input frame_done, output ready);
endinterface

// ===== rtl/sprite_frame_blitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter
// Draws one sprite sheet frame, scaled and optionally mirrored, as a stream
// of framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_px carries one ARGB sheet pixel per item, row-major over the frame.
//   out_wr carries framebuffer results: a transparent pixel gives one result
//   with no write, an opaque one scale*scale results in row-major block
//   order; off-screen positions come out with write_enable low. Every
//   result carries the next sheet fetch index and the frame-done flag.
//   cfg_we/cfg_index/cfg_data write the setup registers while idle.
// Timing:
//   An input item is captured when accepted, then passes the multiply, sum
//   and row-base setup steps before its first result is valid; after that
//   one result per cycle while out_wr.ready is high. in_px.ready is high
//   only between items, so a new item is taken only after the last result.
// Reset: synchronous, active low; state to idle, setup registers to their
//   defaults and the source column and row counters to zero.
// Stall: with out_wr.ready low the current result holds unchanged.
// ----------------------------------------------------------------------------
module sprite_frame_blitter_core
  import sfb_pkg::*;
#(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 240,
  parameter int MAX_FRAME_SIZE = 64,
  parameter int MAX_SCALE      = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sfb_in_if.sink                in_px,
  sfb_out_if.source             out_wr,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  sfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .in_ready (in_px.ready),
    .out_valid(out_wr.valid),
    .out_ready(out_wr.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_FRAME_SIZE(MAX_FRAME_SIZE),
    .MAX_SCALE     (MAX_SCALE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_color  (in_px.pixel_color),
    .write_enable (out_wr.write_enable),
    .pixel_address(out_wr.pixel_address),
    .write_color  (out_wr.write_color),
    .last         (out_wr.last),
    .fetch_address(out_wr.fetch_address),
    .frame_done   (out_wr.frame_done)
  );

endmodule

// ===== rtl/sfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter controller
// Sequences capture, two arithmetic steps, block setup and result emission.
// ----------------------------------------------------------------------------
module sfb_ctrl
  import sfb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    out_valid   = (state_r == ST_EMIT);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.mul     = (state_r == ST_MUL);
    cmd.sum     = (state_r == ST_SUM);
    cmd.base    = (state_r == ST_BASE);
    cmd.step    = (state_r == ST_EMIT) && out_ready;
  end

endmodule

// ===== rtl/sfb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter datapath
// Configuration registers, source counters, address arithmetic and the
// scale by scale block walker.
// ----------------------------------------------------------------------------
module sfb_dp
  import sfb_pkg::*;
#(
  parameter int SCREEN_WIDTH   = 320,
  parameter int SCREEN_HEIGHT  = 240,
  parameter int MAX_FRAME_SIZE = 64,
  parameter int MAX_SCALE      = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               sts,
  input  logic [COLOR_W-1:0]    pixel_color,
  output logic                  write_enable,
  output logic [ADDR_W-1:0]     pixel_address,
  output logic [COLOR_W-1:0]    write_color,
  output logic                  last,
  output logic [FETCH_W-1:0]    fetch_address,
  output logic                  frame_done
);

  localparam int CNT_W = $clog2(MAX_FRAME_SIZE + 1);
  localparam int PX_W  = CNT_W + SCALE_W;
  localparam int PF_W  = CNT_W + STRIDE_W;
  localparam logic [CNT_W:0] ONE_C = (CNT_W + 1)'(1);
  localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] SW_A = ADDR_W'(SCREEN_WIDTH);

  logic [DEST_W-1:0]   dest_x_r, dest_y_r;
  logic [BASE_W-1:0]   src_base_r;
  logic [STRIDE_W-1:0] sheet_width_r;
  logic [FSIZE_W-1:0]  frame_width_r, frame_height_r;
  logic [SCALE_W-1:0]  scale_r;
  logic                mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r       <= '0;
      dest_y_r       <= '0;
      src_base_r     <= '0;
      sheet_width_r  <= STRIDE_W'(1);
      frame_width_r  <= FSIZE_W'(16);
      frame_height_r <= FSIZE_W'(16);
      scale_r        <= SCALE_W'(1);
      mirror_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEST_X:       dest_x_r       <= cfg_data[DEST_W-1:0];
        CFG_DEST_Y:       dest_y_r       <= cfg_data[DEST_W-1:0];
        CFG_SRC_BASE:     src_base_r     <= cfg_data[BASE_W-1:0];
        CFG_SHEET_WIDTH:  sheet_width_r  <= cfg_data[STRIDE_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FSIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FSIZE_W-1:0];
        CFG_SCALE:        scale_r        <= cfg_data[SCALE_W-1:0];
        CFG_MIRROR:       mirror_r       <= cfg_data[0];
        default:          mirror_r       <= mirror_r;
      endcase
    end
  end

  // clamp frame size and scale
  logic [CNT_W-1:0]   fw, fh;
  logic [SCALE_W-1:0] s_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      fw = CNT_W'(1);
    end else if (int'(frame_width_r) > MAX_FRAME_SIZE) begin
      fw = CNT_W'(MAX_FRAME_SIZE);
    end else begin
      fw = CNT_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      fh = CNT_W'(1);
    end else if (int'(frame_height_r) > MAX_FRAME_SIZE) begin
      fh = CNT_W'(MAX_FRAME_SIZE);
    end else begin
      fh = CNT_W'(frame_height_r);
    end
    if (scale_r == '0) begin
      s_eff = SCALE_W'(1);
    end else if (int'(scale_r) > MAX_SCALE) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_r;
    end
  end

  // source counters
  logic [CNT_W-1:0] src_col_r, src_row_r;
  logic [CNT_W-1:0] col_r, row_r;
  logic             done_r;
  logic [CNT_W:0]   c0, r0, nc, nr, fw_x, fh_x;
  logic             done_c;

  always_comb begin
    fw_x   = {1'b0, fw};
    fh_x   = {1'b0, fh};
    c0     = {1'b0, src_col_r};
    r0     = {1'b0, src_row_r};
    if (c0 >= fw_x) begin
      c0 = '0;
      r0 = r0 + ONE_C;
    end
    if (r0 >= fh_x) r0 = '0;
    nc     = c0 + ONE_C;
    nr     = r0;
    done_c = 1'b0;
    if (nc >= fw_x) begin
      nc = '0;
      nr = r0 + ONE_C;
      if (nr >= fh_x) begin
        nr     = '0;
        done_c = 1'b1;
      end
    end
  end

  logic [COLOR_W-1:0] color_r;
  logic               opaque_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
    end else if (cmd.capture) begin
      src_col_r <= nc[CNT_W-1:0];
      src_row_r <= nr[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r    <= c0[CNT_W-1:0];
      row_r    <= r0[CNT_W-1:0];
      done_r   <= done_c;
      color_r  <= pixel_color;
      opaque_r <= |pixel_color[COLOR_W-1:ALPHA_SHIFT];
    end
  end

  // products
  logic [CNT_W-1:0] dcol;
  logic [PX_W-1:0]  prodx_r, prody_r;
  logic [PF_W-1:0]  prodf_r;

  assign dcol = mirror_r ? (fw - CNT_W'(1) - col_r) : col_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prodx_r <= PX_W'(dcol) * PX_W'(s_eff);
      prody_r <= PX_W'(row_r) * PX_W'(s_eff);
      prodf_r <= PF_W'(src_row_r) * PF_W'(sheet_width_r);
    end
  end

  // block origin and fetch index
  logic signed [COORD_W-1:0] bx_r, by_r;
  logic [FETCH_W-1:0]        fetch_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      bx_r    <= $signed({{(COORD_W-DEST_W){dest_x_r[DEST_W-1]}}, dest_x_r})
                 + $signed(COORD_W'(prodx_r));
      by_r    <= $signed({{(COORD_W-DEST_W){dest_y_r[DEST_W-1]}}, dest_y_r})
                 + $signed(COORD_W'(prody_r));
      fetch_r <= FETCH_W'(src_base_r) + FETCH_W'(prodf_r) + FETCH_W'(src_col_r);
    end
  end

  // block walker
  logic signed [2*COORD_W-1:0] ybase;
  logic [ADDR_W-1:0]           rowaddr_r, addr_r, rowaddr_nx;
  logic signed [COORD_W-1:0]   px_r, py_r;
  logic [SCALE_W-1:0]          sx_r, sy_r, s_last;
  logic                        row_end, on;

  assign ybase      = (2*COORD_W)'(by_r) * (2*COORD_W)'(SW_S);
  assign s_last     = s_eff - SCALE_W'(1);
  assign row_end    = (sx_r == s_last);
  assign rowaddr_nx = rowaddr_r + SW_A;

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      rowaddr_r <= ADDR_W'(ybase);
      addr_r    <= ADDR_W'(ybase) + ADDR_W'(bx_r);
      px_r      <= bx_r;
      py_r      <= by_r;
      sx_r      <= '0;
      sy_r      <= '0;
    end else if (cmd.step) begin
      if (row_end) begin
        sx_r      <= '0;
        sy_r      <= sy_r + SCALE_W'(1);
        px_r      <= bx_r;
        py_r      <= py_r + COORD_W'(1);
        rowaddr_r <= rowaddr_nx;
        addr_r    <= rowaddr_nx + ADDR_W'(bx_r);
      end else begin
        sx_r   <= sx_r + SCALE_W'(1);
        px_r   <= px_r + COORD_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  assign on = opaque_r && !px_r[COORD_W-1] && (px_r < SW_S)
              && !py_r[COORD_W-1] && (py_r < SH_S);

  assign sts.last      = !opaque_r || (row_end && (sy_r == s_last));
  assign write_enable  = on;
  assign pixel_address = on ? addr_r : '0;
  assign write_color   = on ? color_r : '0;
  assign last          = sts.last;
  assign fetch_address = fetch_r;
  assign frame_done    = done_r;

endmodule

// ===== rtl/sfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame blitter port checker
// Port-level checks on item sequencing and result timing.
// ----------------------------------------------------------------------------
module sfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [16:0] out_pixel_address,
  input logic [17:0] out_fetch_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_address)
      && $stable(out_fetch_address) && $stable(out_last))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##4 out_valid)
    else $error("first result not on time");

  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("results stopped before last");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not ready after last result");

endmodule

bind sprite_frame_blitter_core sfb_checker u_sfb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_px.valid),
  .in_ready         (in_px.ready),
  .out_valid        (out_wr.valid),
  .out_ready        (out_wr.ready),
  .out_last         (out_wr.last),
  .out_pixel_address(out_wr.pixel_address),
  .out_fetch_address(out_wr.fetch_address)
);
